@@ src/c3r_pkg.sv @@
// ----------------------------------------------------------------------------
// c3r_pkg: shared types and constants
// Constants, request codes and the command format passed from the front end
// to the compute back end of the 3x3 convolution engine.
// ----------------------------------------------------------------------------
package c3r_pkg;

   localparam int DEF_MAX_WIDTH = 16;
   localparam int DEF_MAX_CIN   = 8;
   localparam int DEF_MAX_COUT  = 16;

   localparam int Q_SHIFT    = 11;
   localparam int SAT_HIGH   = 32767;
   localparam int KSIZE      = 3;
   localparam int MAX_HEIGHT = 1024;

   localparam int QUEUE_DEPTH = 4;

   // Command field widths cover the whole parameter range.
   localparam int CMD_ADDR_W = 16;
   localparam int CMD_COL_W  = 6;
   localparam int CMD_CNT_W  = 7;

   // Configuration register indexes.
   localparam logic [1:0] CSR_IN_HEIGHT    = 2'd0;
   localparam logic [1:0] CSR_IN_WIDTH     = 2'd1;
   localparam logic [1:0] CSR_IN_CHANNELS  = 2'd2;
   localparam logic [1:0] CSR_OUT_CHANNELS = 2'd3;

   typedef enum logic [1:0] {
      REQ_KERNEL = 2'd0,
      REQ_BIAS   = 2'd1,
      REQ_ACT    = 2'd2
   } req_kind_type;

   typedef struct packed {
      req_kind_type           kind;
      logic [CMD_ADDR_W-1:0]  addr;
      logic signed [15:0]     value;
      logic                   fire;
      logic                   frame_end;
      logic [1:0]             rmod;
      logic [9:0]             row;
      logic [CMD_COL_W-1:0]   col;
      logic [CMD_CNT_W-1:0]   cin;
      logic [CMD_CNT_W-1:0]   cout;
   } cmd_type;

   function automatic int clamp_int(input int v, input int lo, input int hi);
      int r;
      r = v;
      if (v < lo) r = lo;
      if (v > hi) r = hi;
      return r;
   endfunction

endpackage

@@ src/c3r_front.sv @@
// ----------------------------------------------------------------------------
// c3r_front: request front end
// Takes request beats, holds the configuration and the frame position, and
// turns each useful request into a command for the back end.
// ----------------------------------------------------------------------------
module c3r_front #(
   parameter int MAX_WIDTH = 16,
   parameter int MAX_CIN   = 8,
   parameter int MAX_COUT  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [10:0]        req_address,
   input  logic signed [15:0] req_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_data,
   output logic               q_push,
   output c3r_pkg::cmd_type   q_data,
   input  logic               q_full
);
   import c3r_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int CI_W   = (MAX_CIN > 1) ? $clog2(MAX_CIN) : 1;
   localparam int CIN_W  = (MAX_CIN > 1) ? $clog2(MAX_CIN + 1) : 1;
   localparam int COUT_W = $clog2(MAX_COUT + 1);
   localparam int KDEPTH = MAX_COUT * KSIZE * KSIZE * MAX_CIN;
   localparam int W_RST  = clamp_int(13, 3, MAX_WIDTH);
   localparam int CI_RST = clamp_int(1, 1, MAX_CIN);
   localparam int CO_RST = clamp_int(8, 1, MAX_COUT);

   logic [10:0]       h_ff;
   logic [WID_W-1:0]  w_ff;
   logic [CIN_W-1:0]  cin_ff;
   logic [COUT_W-1:0] cout_ff;
   logic [9:0]        row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [CI_W-1:0]   ch_ff;
   logic [1:0]        rmod_ff;

   logic        accept;
   logic        is_act;
   logic        ch_last;
   logic        col_last;
   logic        row_last;
   logic [10:0] h_in;
   logic [4:0]  w_raw;
   logic [3:0]  ci_raw;
   logic [4:0]  co_raw;

   assign req_stall = q_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !q_full;
   assign is_act    = (req_type == REQ_ACT);

   assign ch_last  = (CIN_W'(ch_ff) == cin_ff - CIN_W'(1));
   assign col_last = (WID_W'(col_ff) == w_ff - WID_W'(1));
   assign row_last = ({1'b0, row_ff} == h_ff - 11'd1);

   assign w_raw  = csr_data[4:0];
   assign ci_raw = csr_data[3:0];
   assign co_raw = csr_data[4:0];

   always_comb begin
      if (csr_data < 11'd3) begin
         h_in = 11'd3;
      end else if (int'(csr_data) > MAX_HEIGHT) begin
         h_in = 11'(MAX_HEIGHT);
      end else begin
         h_in = csr_data;
      end
   end

   always_comb begin
      q_data = '0;
      q_data.value = req_value;
      q_data.cin   = CMD_CNT_W'(cin_ff);
      q_data.cout  = CMD_CNT_W'(cout_ff);
      q_data.row   = row_ff;
      q_data.col   = CMD_COL_W'(col_ff);
      q_data.rmod  = rmod_ff;
      q_data.fire  = ch_last && (row_ff >= 10'd2) && (col_ff >= COL_W'(2));
      q_data.frame_end = row_last && col_last;
      q_push = 1'b0;
      q_data.kind = REQ_ACT;
      case (req_type)
         REQ_KERNEL: begin
            q_data.kind = REQ_KERNEL;
            q_data.addr = CMD_ADDR_W'(req_address);
            q_push = accept && (int'(req_address) < KDEPTH);
         end
         REQ_BIAS: begin
            q_data.kind = REQ_BIAS;
            q_data.addr = CMD_ADDR_W'(req_address);
            q_push = accept && (int'(req_address) < MAX_COUT);
         end
         REQ_ACT: begin
            q_data.addr = CMD_ADDR_W'((int'(rmod_ff) * MAX_WIDTH + int'(col_ff)) * MAX_CIN
                                      + int'(ch_ff));
            q_push = accept;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff    <= 11'd62;
         w_ff    <= WID_W'(W_RST);
         cin_ff  <= CIN_W'(CI_RST);
         cout_ff <= COUT_W'(CO_RST);
         row_ff  <= '0;
         col_ff  <= '0;
         ch_ff   <= '0;
         rmod_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IN_HEIGHT: h_ff <= h_in;
            CSR_IN_WIDTH: begin
               if (w_raw < 5'd3) w_ff <= WID_W'(3);
               else if (int'(w_raw) > MAX_WIDTH) w_ff <= WID_W'(MAX_WIDTH);
               else w_ff <= WID_W'(w_raw);
            end
            CSR_IN_CHANNELS: begin
               if (ci_raw == 4'd0) cin_ff <= CIN_W'(1);
               else if (int'(ci_raw) > MAX_CIN) cin_ff <= CIN_W'(MAX_CIN);
               else cin_ff <= CIN_W'(ci_raw);
            end
            default: begin
               if (co_raw == 5'd0) cout_ff <= COUT_W'(1);
               else if (int'(co_raw) > MAX_COUT) cout_ff <= COUT_W'(MAX_COUT);
               else cout_ff <= COUT_W'(co_raw);
            end
         endcase
         row_ff  <= '0;
         col_ff  <= '0;
         ch_ff   <= '0;
         rmod_ff <= '0;
      end else if (accept && is_act) begin
         if (ch_last) begin
            ch_ff <= '0;
            if (col_last) begin
               col_ff <= '0;
               if (row_last) begin
                  row_ff  <= '0;
                  rmod_ff <= '0;
               end else begin
                  row_ff  <= row_ff + 10'd1;
                  rmod_ff <= (rmod_ff == 2'd2) ? 2'd0 : rmod_ff + 2'd1;
               end
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end else begin
            ch_ff <= ch_ff + CI_W'(1);
         end
      end
   end

endmodule

@@ src/c3r_queue.sv @@
// ----------------------------------------------------------------------------
// c3r_queue: command queue
// A short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module c3r_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  c3r_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output c3r_pkg::cmd_type head,
   output logic             empty
);
   import c3r_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff;
   logic [PTR_W-1:0]  rd_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + PTR_W'(1);
         if (do_pop) rd_ff <= rd_ff + PTR_W'(1);
         if (do_push && !do_pop) count_ff <= count_ff + CNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

@@ src/c3r_back.sv @@
// ----------------------------------------------------------------------------
// c3r_back: compute back end
// Owns the kernel, bias and line stores, and runs the multiply-accumulate
// sequence for each output channel of a finished pixel.
// ----------------------------------------------------------------------------
module c3r_back #(
   parameter int MAX_WIDTH = 16,
   parameter int MAX_CIN   = 8,
   parameter int MAX_COUT  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  c3r_pkg::cmd_type head,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [14:0]      rsp_result_value,
   output logic [9:0]       rsp_out_row,
   output logic [3:0]       rsp_out_col,
   output logic [3:0]       rsp_out_channel,
   output logic             rsp_last_of_pixel,
   output logic             rsp_last_of_frame
);
   import c3r_pkg::*;

   localparam int LINE_DEPTH = KSIZE * MAX_WIDTH * MAX_CIN;
   localparam int KDEPTH     = MAX_COUT * KSIZE * KSIZE * MAX_CIN;
   localparam int LA_W       = $clog2(LINE_DEPTH);
   localparam int K_W        = $clog2(KDEPTH);
   localparam int CO_IW      = (MAX_COUT > 1) ? $clog2(MAX_COUT) : 1;
   localparam int CI_W       = (MAX_CIN > 1) ? $clog2(MAX_CIN) : 1;
   localparam int ACC_W      = 33 + $clog2(KSIZE * KSIZE * MAX_CIN + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIAS,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   logic signed [15:0] line_mem [LINE_DEPTH];
   logic signed [15:0] kern_mem [KDEPTH];
   logic signed [15:0] bias_mem [MAX_COUT];

   state_type          state_ff;
   cmd_type            cur_ff;
   logic [CO_IW-1:0]   co_ff;
   logic [1:0]         kh_ff;
   logic [1:0]         kw_ff;
   logic [CI_W-1:0]    ci_ff;
   logic [K_W-1:0]     kidx_ff;
   logic               first_ff;
   logic               p1_valid_ff;
   logic               p1_last_ff;
   logic               p2_valid_ff;
   logic               p2_last_ff;

   logic signed [15:0]      line_rd_ff;
   logic signed [15:0]      kern_rd_ff;
   logic signed [15:0]      bias_rd_ff;
   logic signed [31:0]      prod_ff;
   logic signed [ACC_W-1:0] acc_ff;

   logic [2:0]              slot_sum;
   logic [1:0]              slot;
   logic [LA_W-1:0]         tap_addr;
   logic                    tap_last;
   logic                    co_last;
   logic                    out_free;
   logic signed [ACC_W-1:0] shifted;
   logic [14:0]             result_in;

   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign tap_last = (kh_ff == 2'd2) && (kw_ff == 2'd2)
                     && (CMD_CNT_W'(ci_ff) == cur_ff.cin - CMD_CNT_W'(1));
   assign co_last  = (CMD_CNT_W'(co_ff) == cur_ff.cout - CMD_CNT_W'(1));
   assign out_free = !rsp_valid || !rsp_stall;

   // Ring slot of input row (row - 2 + kh) is (rmod + 1 + kh) mod 3.
   assign slot_sum = 3'(cur_ff.rmod) + 3'(kh_ff) + 3'd1;
   assign slot     = (slot_sum >= 3'd3) ? 2'(slot_sum - 3'd3) : 2'(slot_sum);
   assign tap_addr = LA_W'((int'(slot) * MAX_WIDTH + int'(cur_ff.col) - 2 + int'(kw_ff))
                           * MAX_CIN + int'(ci_ff));

   assign shifted = acc_ff >>> Q_SHIFT;
   always_comb begin
      if (acc_ff[ACC_W-1]) begin
         result_in = '0;
      end else if (shifted > ACC_W'(SAT_HIGH)) begin
         result_in = 15'(SAT_HIGH);
      end else begin
         result_in = shifted[14:0];
      end
   end

   // Stores: written from queued load and activation commands.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         case (head.kind)
            REQ_KERNEL: kern_mem[head.addr[K_W-1:0]] <= head.value;
            REQ_BIAS:   bias_mem[head.addr[CO_IW-1:0]] <= head.value;
            default:    line_mem[head.addr[LA_W-1:0]] <= head.value;
         endcase
      end
      line_rd_ff <= line_mem[tap_addr];
      kern_rd_ff <= kern_mem[kidx_ff];
      bias_rd_ff <= bias_mem[co_ff];
   end

   // Datapath: product register, then accumulator.
   always_ff @(posedge clock) begin
      prod_ff <= line_rd_ff * kern_rd_ff;
      if (first_ff) begin
         acc_ff <= ACC_W'(bias_rd_ff) <<< Q_SHIFT;
      end else if (p2_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         co_ff       <= '0;
         kh_ff       <= '0;
         kw_ff       <= '0;
         ci_ff       <= '0;
         kidx_ff     <= '0;
         first_ff    <= 1'b0;
         p1_valid_ff <= 1'b0;
         p1_last_ff  <= 1'b0;
         p2_valid_ff <= 1'b0;
         p2_last_ff  <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
         p2_last_ff  <= p1_last_ff;
         p1_valid_ff <= 1'b0;
         p1_last_ff  <= 1'b0;
         first_ff    <= 1'b0;
         if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop && head.kind == REQ_ACT && head.fire) begin
                  cur_ff   <= head;
                  co_ff    <= '0;
                  kidx_ff  <= '0;
                  state_ff <= ST_BIAS;
               end
            end
            ST_BIAS: begin
               first_ff <= 1'b1;
               kh_ff    <= '0;
               kw_ff    <= '0;
               ci_ff    <= '0;
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               p1_valid_ff <= 1'b1;
               p1_last_ff  <= tap_last;
               kidx_ff     <= kidx_ff + K_W'(1);
               if (CMD_CNT_W'(ci_ff) == cur_ff.cin - CMD_CNT_W'(1)) begin
                  ci_ff <= '0;
                  if (kw_ff == 2'd2) begin
                     kw_ff <= '0;
                     kh_ff <= kh_ff + 2'd1;
                  end else begin
                     kw_ff <= kw_ff + 2'd1;
                  end
               end else begin
                  ci_ff <= ci_ff + CI_W'(1);
               end
               if (tap_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (p2_valid_ff && p2_last_ff) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid         <= 1'b1;
                  rsp_result_value  <= result_in;
                  rsp_out_row       <= cur_ff.row - 10'd2;
                  rsp_out_col       <= 4'(cur_ff.col - CMD_COL_W'(2));
                  rsp_out_channel   <= 4'(co_ff);
                  rsp_last_of_pixel <= co_last;
                  rsp_last_of_frame <= co_last && cur_ff.frame_end;
                  if (co_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     co_ff    <= co_ff + CO_IW'(1);
                     state_ff <= ST_BIAS;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ src/conv3x3_relu_q11_engine_unit.sv @@
// ----------------------------------------------------------------------------
// conv3x3_relu_q11_engine_unit: streaming 3x3 convolution with ReLU
// Q11 3x3 valid convolution over a streamed feature map, with kernel and
// bias loading, a three-row line store and saturating ReLU output.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Beat contents
//   req_      in         valid / stall      type, address, value
//   rsp_      out        valid / stall      result, row, column, channel, lasts
//   csr_      in         valid / ready      register index, write data
//
// A load beat or an activation beat that completes no pixel is only popped
// from the queue and written to its store by the back end. A beat that
// completes an output pixel is popped and then, per output channel, runs a
// bias step, the taps of its 3x3 window over all input channels through the
// single shared multiplier, which reads one kernel word and one line word
// per cycle, a drain and an emit step. A four-entry command queue lets
// request beats keep arriving while the back end computes.
// Reset is synchronous and active high; it restores the default geometry
// and the frame position. The stores are undefined until loaded.
// A stalled result holds the back end in its emit step; the queue fills and
// then req_stall rises. Configuration writes are always ready and restart
// the frame position.
module conv3x3_relu_q11_engine_unit
   import c3r_pkg::*;
#(
   parameter int MAX_WIDTH        = DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS_IN  = DEF_MAX_CIN,
   parameter int MAX_CHANNELS_OUT = DEF_MAX_COUT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [10:0]        req_address,
   input  logic signed [15:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_result_value,
   output logic [9:0]         rsp_out_row,
   output logic [3:0]         rsp_out_col,
   output logic [3:0]         rsp_out_channel,
   output logic               rsp_last_of_pixel,
   output logic               rsp_last_of_frame,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_data
);

   // Commands flow from the front end through the queue to the back end.
   cmd_type push_data;
   cmd_type head;
   logic    push;
   logic    full;
   logic    pop;
   logic    empty;

   c3r_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_CIN   (MAX_CHANNELS_IN),
      .MAX_COUT  (MAX_CHANNELS_OUT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_address (req_address),
      .req_value   (req_value),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_push      (push),
      .q_data      (push_data),
      .q_full      (full)
   );

   c3r_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   // The back end owns all three stores and the result register.
   c3r_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_CIN   (MAX_CHANNELS_IN),
      .MAX_COUT  (MAX_CHANNELS_OUT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_empty           (empty),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_last_of_pixel (rsp_last_of_pixel),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

@@ src/c3r_checker.sv @@
// ----------------------------------------------------------------------------
// c3r_checker: port-level checks
// Watches the result channel of the convolution engine over time.
// ----------------------------------------------------------------------------
module c3r_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [14:0] rsp_result_value,
   input logic [9:0]  rsp_out_row,
   input logic [3:0]  rsp_out_col,
   input logic [3:0]  rsp_out_channel,
   input logic        rsp_last_of_pixel,
   input logic        rsp_last_of_frame
);

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_result_value) && $stable(rsp_out_channel)
                                 && $stable(rsp_out_row) && $stable(rsp_out_col))
      else $error("result payload changed while stalled");

   a_frame_ends_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_frame |-> rsp_last_of_pixel)
      else $error("frame end flagged on a beat that does not end its pixel");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind conv3x3_relu_q11_engine_unit c3r_checker u_c3r_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_result_value  (rsp_result_value),
   .rsp_out_row       (rsp_out_row),
   .rsp_out_col       (rsp_out_col),
   .rsp_out_channel   (rsp_out_channel),
   .rsp_last_of_pixel (rsp_last_of_pixel),
   .rsp_last_of_frame (rsp_last_of_frame)
);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 3x3 convolution engine
// Loads the kernel and bias stores, streams activation maps under several
// geometries and predicts every output beat in the bench itself. Both
// channels idle and stall at random, with one long receiver hold-off and one
// sender pause until the engine has drained.
// ----------------------------------------------------------------------------
module tb;
   import c3r_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int KERN_WORDS = 16 * 9 * 8;
   localparam int LINE_WORDS = 3 * 16 * 8;
   localparam int DRAIN_CYCLES = 64;

   // One predicted output beat.
   typedef struct {
      logic [14:0] value;
      logic [9:0]  row;
      logic [3:0]  col;
      logic [3:0]  chan;
      logic        last_pixel;
      logic        last_frame;
   } conv_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = 2'd0;
   logic [10:0]        req_address = '0;
   logic signed [15:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [14:0]        rsp_result_value;
   logic [9:0]         rsp_out_row;
   logic [3:0]         rsp_out_col;
   logic [3:0]         rsp_out_channel;
   logic               rsp_last_of_pixel;
   logic               rsp_last_of_frame;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [10:0]        csr_data = '0;

   conv3x3_relu_q11_engine_unit dut (.*);

   // The clock runs with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Bench copy of the engine state. Registers keep the bits the engine
   // reads, unclamped, and are clamped into range whenever they are used.
   logic signed [15:0] kern_mem [KERN_WORDS];
   logic signed [15:0] bias_mem [16];
   logic signed [15:0] line_mem [LINE_WORDS];
   int unsigned        reg_height = 62, reg_width = 13, reg_cin = 1, reg_cout = 8;
   int unsigned        pos_row = 0, pos_col = 0, pos_chan = 0;

   conv_out_type pixel_results[$];

   int  error_count = 0;
   int  beats_sent = 0;
   int  results_seen = 0;
   int  csr_writes = 0;
   bit  sender_calm = 0;   // when set, the sender offers back-to-back beats
   bit  receiver_calm = 0; // when set, the receiver never stalls on its own
   int  hold_left = 0;     // a long receiver hold-off, counted in cycles
   int  run_left = 0;

   function automatic int unsigned clamp_u(int unsigned v, int unsigned lo,
                                           int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int line_slot(int unsigned row, int unsigned col,
                                    int unsigned ch);
      return ((row % 3) * 16 + col) * 8 + ch;
   endfunction

   // Works out what one accepted request beat does to the state and which
   // output beats it causes; those are appended to pixel_results.
   task automatic predict_conv_beat(input logic [1:0] kind, input logic [10:0] addr,
                                    input logic signed [15:0] val);
      int unsigned h, w, cin, cout, row, col, ch;
      longint acc;
      conv_out_type item;
      h    = clamp_u(reg_height, 3, 1024);
      w    = clamp_u(reg_width, 3, 16);
      cin  = clamp_u(reg_cin, 1, 8);
      cout = clamp_u(reg_cout, 1, 16);
      if (kind == REQ_KERNEL) begin
         if (addr < KERN_WORDS) kern_mem[addr] = val;
         return;
      end
      if (kind == REQ_BIAS) begin
         if (addr < 16) bias_mem[addr] = val;
         return;
      end
      if (kind != REQ_ACT) return;

      if (pos_row >= h) pos_row = 0;
      if (pos_col >= w) pos_col = 0;
      if (pos_chan >= cin) pos_chan = 0;
      row = pos_row;
      col = pos_col;
      ch  = pos_chan;
      line_mem[line_slot(row, col, ch)] = val;

      // The last channel of a pixel with a full 3x3 window behind it fires
      // one output beat per filter.
      if (ch == cin - 1 && row >= 2 && col >= 2) begin
         for (int co = 0; co < cout; co++) begin
            acc = longint'(bias_mem[co]) * 2048;
            for (int kh = 0; kh < 3; kh++)
               for (int kw = 0; kw < 3; kw++)
                  for (int ci = 0; ci < cin; ci++)
                     acc += longint'(line_mem[line_slot(row - 2 + kh, col - 2 + kw, ci)])
                          * longint'(kern_mem[co * 9 * cin + kh * 3 * cin + kw * cin + ci]);
            if (acc < 0) item.value = '0;
            else if ((acc >>> Q_SHIFT) > SAT_HIGH) item.value = 15'h7fff;
            else item.value = 15'(acc >>> Q_SHIFT);
            item.row        = 10'(row - 2);
            item.col        = 4'(col - 2);
            item.chan       = 4'(co);
            item.last_pixel = (co == cout - 1);
            item.last_frame = (co == cout - 1) && (row == h - 1) && (col == w - 1);
            pixel_results.push_back(item);
         end
      end

      pos_chan = ch + 1;
      if (pos_chan >= cin) begin
         pos_chan = 0;
         pos_col = col + 1;
         if (pos_col >= w) begin
            pos_col = 0;
            pos_row = row + 1;
            if (pos_row >= h) pos_row = 0;
         end
      end
   endtask

   // Sender gaps: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (sender_calm) return 0;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Activation or load word: full range, small magnitudes and both rails.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2, 3: return 16'($urandom_range(0, 4095) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   // Offers one request beat and holds it until the engine takes it. Called
   // just after a rising edge; returns just after the accepting edge, or
   // after the idle gap that follows it.
   task automatic send_beat(input logic [1:0] kind, input logic [10:0] addr,
                            input logic [15:0] val);
      int gap;
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_address <= addr;
      req_value   <= val;
      do @(posedge clock); while (req_stall);
      predict_conv_beat(kind, addr, val);
      beats_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_act(input logic [15:0] val);
      send_beat(REQ_ACT, 11'($urandom), val);
   endtask

   // Waits until every predicted beat has come out, then lets the engine
   // finish any work that has no visible output.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixel_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only with the engine idle; any write restarts
   // the frame position.
   task automatic write_csr(input logic [1:0] idx, input logic [10:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_IN_HEIGHT:    reg_height = data;
         CSR_IN_WIDTH:     reg_width  = data & 11'h1f;
         CSR_IN_CHANNELS:  reg_cin    = data & 11'h0f;
         CSR_OUT_CHANNELS: reg_cout   = data & 11'h1f;
         default: ;
      endcase
      pos_row  = 0;
      pos_col  = 0;
      pos_chan = 0;
      csr_writes++;
   endtask

   task automatic set_geometry(input int unsigned h, input int unsigned w,
                               input int unsigned cin, input int unsigned cout);
      write_csr(CSR_IN_HEIGHT, 11'(h));
      write_csr(CSR_IN_WIDTH, 11'(w));
      write_csr(CSR_IN_CHANNELS, 11'(cin));
      write_csr(CSR_OUT_CHANNELS, 11'(cout));
   endtask

   // Fills every kernel word and every bias, so that no later result can
   // touch an entry that was never written.
   task automatic test_store_load();
      sender_calm = 1;
      for (int a = 0; a < KERN_WORDS; a++) send_beat(REQ_KERNEL, 11'(a), pick_word());
      for (int a = 0; a < 16; a++) send_beat(REQ_BIAS, 11'(a), pick_word());
      sender_calm = 0;
   endtask

   // Directed cases: smallest frame with its end flag and wrap into the next
   // frame, saturation at both ends, ignored loads and the unused request
   // code, and registers written past both ends of their ranges.
   task automatic test_directed();
      set_geometry(3, 3, 1, 2);
      // Filter 0 drives far past the top rail, filter 1 far below zero.
      for (int a = 0; a < 9; a++) send_beat(REQ_KERNEL, 11'(a), 16'h7fff);
      for (int a = 9; a < 18; a++) send_beat(REQ_KERNEL, 11'(a), 16'h8000);
      send_beat(REQ_BIAS, 11'd0, 16'h7fff);
      send_beat(REQ_BIAS, 11'd1, 16'h8000);
      for (int i = 0; i < 9; i++) send_act(16'h7fff);
      // Out-of-range loads and the unused code change nothing.
      send_beat(REQ_KERNEL, 11'd1152, 16'h0000);
      send_beat(REQ_KERNEL, 11'd2047, 16'h0000);
      send_beat(REQ_BIAS, 11'd16, 16'h0000);
      send_beat(2'd3, 11'h7ff, 16'hffff);
      // Second frame after the wrap, with the most negative input.
      for (int i = 0; i < 9; i++) send_act(16'h8000);
      // Registers below their ranges clamp to the minimum geometry.
      set_geometry(0, 0, 0, 0);
      for (int i = 0; i < 9; i++) send_act(pick_word());
      // Registers at the all-ones pattern clamp to the maximum geometry.
      set_geometry(11'h7ff, 11'h7ff, 11'h7ff, 11'h7ff);
      for (int i = 0; i < 16 * 8 * 2 + 3 * 8; i++) send_act(pick_word());
   endtask

   // Random geometries, mostly small, streamed as runs of any length, with
   // a sprinkling of reloads, ignored beats and register changes.
   task automatic test_random(input int target);
      int n, h, w, cin, cout, len;
      n = 0;
      while (n < target) begin
         if ($urandom_range(0, 6) == 0) begin
            set_geometry($urandom, $urandom, $urandom, $urandom);
         end else begin
            set_geometry($urandom_range(3, 5), $urandom_range(3, 6),
                         $urandom_range(1, 3), $urandom_range(1, 4));
         end
         h    = clamp_u(reg_height, 3, 1024);
         w    = clamp_u(reg_width, 3, 16);
         cin  = clamp_u(reg_cin, 1, 8);
         cout = clamp_u(reg_cout, 1, 16);
         if (h > 5) h = 3;
         len = $urandom_range(w * cin * 3, w * cin * (h + 1));
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 19))
               0: send_beat(REQ_KERNEL, 11'($urandom), pick_word());
               1: send_beat(REQ_BIAS, 11'($urandom_range(0, 31)), pick_word());
               2: send_beat(2'd3, 11'($urandom), 16'($urandom));
               default: begin
                  send_act(pick_word());
                  n++;
               end
            endcase
         end
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering beats back to back, so the queue fills and req_stall rises.
   task automatic test_backpressure();
      set_geometry(4, 8, 1, 2);
      sender_calm = 1;
      hold_left = 400;
      for (int i = 0; i < 32; i++) send_act(pick_word());
      sender_calm = 0;
   endtask

   // The sender stops until every expected beat has come out, then resumes
   // mid-frame.
   task automatic test_pause_midframe();
      set_geometry(5, 4, 2, 3);
      for (int i = 0; i < 20; i++) send_act(pick_word());
      wait_drained();
      for (int i = 0; i < 20; i++) send_act(pick_word());
   endtask

   // Receiver stall pattern: random runs, mostly short, some long, and the
   // long hold-off when a test asks for it.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (run_left > 0) begin
         run_left = run_left - 1;
      end else if (receiver_calm) begin
         rsp_stall <= 1'b0;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               rsp_stall <= 1'b0;
               run_left = $urandom_range(0, 12);
            end
            6, 7, 8: begin
               rsp_stall <= 1'b1;
               run_left = $urandom_range(0, 3);
            end
            default: begin
               rsp_stall <= 1'b1;
               run_left = $urandom_range(20, 60);
            end
         endcase
      end
   end

   // Every accepted output beat is checked against the oldest prediction.
   always @(posedge clock) begin
      conv_out_type exp_beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pixel_results.size() == 0) begin
            $display("%0t: unexpected output beat, actual value %0d row %0d col %0d ch %0d",
                     $time, rsp_result_value, rsp_out_row, rsp_out_col, rsp_out_channel);
            error_count++;
         end else begin
            exp_beat = pixel_results.pop_front();
            if (rsp_result_value !== exp_beat.value) begin
               $display("%0t: result_value expected %0d actual %0d", $time,
                        exp_beat.value, rsp_result_value);
               error_count++;
            end
            if (rsp_out_row !== exp_beat.row) begin
               $display("%0t: out_row expected %0d actual %0d", $time,
                        exp_beat.row, rsp_out_row);
               error_count++;
            end
            if (rsp_out_col !== exp_beat.col) begin
               $display("%0t: out_col expected %0d actual %0d", $time,
                        exp_beat.col, rsp_out_col);
               error_count++;
            end
            if (rsp_out_channel !== exp_beat.chan) begin
               $display("%0t: out_channel expected %0d actual %0d", $time,
                        exp_beat.chan, rsp_out_channel);
               error_count++;
            end
            if (rsp_last_of_pixel !== exp_beat.last_pixel) begin
               $display("%0t: last_of_pixel expected %0b actual %0b", $time,
                        exp_beat.last_pixel, rsp_last_of_pixel);
               error_count++;
            end
            if (rsp_last_of_frame !== exp_beat.last_frame) begin
               $display("%0t: last_of_frame expected %0b actual %0b", $time,
                        exp_beat.last_frame, rsp_last_of_frame);
               error_count++;
            end
         end
      end
   end

   // Main sequence: reset once, then the tests in turn, then the drain and
   // the verdict.
   initial begin
      foreach (line_mem[i]) line_mem[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_store_load();
      test_directed();
      test_backpressure();
      test_pause_midframe();
      test_random(150);
      wait_drained();
      $display("Run covered %0d request beats, %0d output beats, %0d register writes,",
               beats_sent, results_seen, csr_writes);
      $display("with saturation, clamped geometries, frame wrap and long back-pressure.");
      if (error_count == 0 && pixel_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

endmodule
